/* rtl/lcdq_pkg.sv */
// Shared types, codes and helper functions for the LCD timed command queue.
// No dependencies; every other file of the block imports this package.
package lcdq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF   = 32;

	localparam int NOW_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int REQ_W     = 3;
	localparam int ROW_W     = 2;
	localparam int COL_W     = 5;
	localparam int QCOUNT_W  = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;
	localparam int NEED_W    = 3;

	localparam logic [BYTE_W-1:0] CLEAR_WAIT_RST = 8'd123;
	localparam logic [BYTE_W-1:0] CHAR_WAIT_RST  = 8'd4;
	localparam logic [BYTE_W-1:0] SET_DDRAM_BASE = 8'h80;
	localparam logic [BYTE_W-1:0] INSTR_CLEAR    = 8'h01;
	localparam logic [BYTE_W-1:0] INSTR_HOME     = 8'h02;

	localparam logic [BYTE_W-1:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WAIT  = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PROCESS    = 3'd0,
		REQ_PUSH_INSTR = 3'd1,
		REQ_PUSH_DATA  = 3'd2,
		REQ_PUSH_WAIT  = 3'd3,
		REQ_CLEAR      = 3'd4,
		REQ_TEXT       = 3'd5,
		REQ_CHAR_AT    = 3'd6
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_INSTR = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_WAIT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] value;
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_PUSH,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       accept;
		logic       decode;
		logic       exec;
		logic       push;
		logic [1:0] push_idx;
		logic       finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic              is_proc;
		logic              nonempty;
		logic [NEED_W-1:0] need;
		logic              fits;
		logic              out_free;
	} dp_status_t;

	function automatic logic [NEED_W-1:0] need_of(input logic [REQ_W-1:0] req);
		logic [NEED_W-1:0] n;
		case (req)
			REQ_PUSH_INSTR, REQ_PUSH_DATA, REQ_PUSH_WAIT: n = 3'd1;
			REQ_TEXT:                                     n = 3'd2;
			REQ_CLEAR, REQ_CHAR_AT:                       n = 3'd4;
			default:                                      n = 3'd0;
		endcase
		return n;
	endfunction

	// Action number idx of the sequence that a request expands into.
	function automatic action_t push_entry(
		input logic [REQ_W-1:0]  req,
		input logic [1:0]        idx,
		input logic [BYTE_W-1:0] byte_v,
		input logic [BYTE_W-1:0] wcount,
		input logic [BYTE_W-1:0] addr,
		input logic [BYTE_W-1:0] clr_wait,
		input logic [BYTE_W-1:0] chr_wait
	);
		action_t a;
		case (req)
			REQ_PUSH_INSTR: a = '{kind: KIND_INSTR, value: byte_v};
			REQ_PUSH_DATA:  a = '{kind: KIND_DATA, value: byte_v};
			REQ_PUSH_WAIT:  a = '{kind: KIND_WAIT, value: wcount};
			REQ_CLEAR: begin
				if (idx[0])      a = '{kind: KIND_WAIT, value: clr_wait};
				else if (idx[1]) a = '{kind: KIND_INSTR, value: INSTR_HOME};
				else             a = '{kind: KIND_INSTR, value: INSTR_CLEAR};
			end
			REQ_TEXT: begin
				if (idx[0]) a = '{kind: KIND_WAIT, value: chr_wait};
				else        a = '{kind: KIND_DATA, value: byte_v};
			end
			REQ_CHAR_AT: begin
				if (idx[0])      a = '{kind: KIND_WAIT, value: chr_wait};
				else if (idx[1]) a = '{kind: KIND_DATA, value: byte_v};
				else             a = '{kind: KIND_INSTR, value: addr};
			end
			default: a = '{kind: KIND_WAIT, value: '0};
		endcase
		return a;
	endfunction

endpackage

/* rtl/lcdq_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on lcdq_pkg for field widths.
interface lcdq_req_if;
	import lcdq_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [NOW_W-1:0]    now_time;
	logic [BYTE_W-1:0]   byte_value;
	logic [BYTE_W-1:0]   wait_count;
	logic [ROW_W-1:0]    row;
	logic [COL_W-1:0]    column;

	modport source (output valid, req_type, now_time, byte_value, wait_count, row, column,
		input ready);
	modport sink (input valid, req_type, now_time, byte_value, wait_count, row, column,
		output ready);
endinterface

interface lcdq_res_if;
	import lcdq_pkg::*;
	logic                valid;
	logic                ready;
	logic                bus_write;
	logic                reg_select;
	logic [BYTE_W-1:0]   bus_byte;
	logic                dropped;
	logic [QCOUNT_W-1:0] queue_count;

	modport source (output valid, bus_write, reg_select, bus_byte, dropped, queue_count,
		input ready);
	modport sink (input valid, bus_write, reg_select, bus_byte, dropped, queue_count,
		output ready);
endinterface

/* rtl/lcdq_ctrl.sv */
// Sequencing state machine for the LCD command queue.
// Depends on lcdq_pkg; drives lcdq_datapath through dp_cmd_t.
module lcdq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lcdq_pkg::dp_status_t  status,
	output lcdq_pkg::dp_cmd_t     cmd
);
	import lcdq_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] idx_q;
	logic       last_push;

	assign last_push = ({1'b0, idx_q} == (status.need - 3'd1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				if (status.is_proc && status.nonempty)      state_d = ST_EXEC;
				else if (status.need != '0 && status.fits) state_d = ST_PUSH;
				else                                        state_d = ST_DONE;
			end
			ST_EXEC:   state_d = ST_DONE;
			ST_PUSH:   if (last_push) state_d = ST_DONE;
			ST_DONE:   if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		cmd.push_idx = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DECODE: cmd.decode = 1'b1;
			ST_EXEC:   cmd.exec   = 1'b1;
			ST_PUSH:   cmd.push   = 1'b1;
			ST_DONE:   cmd.finish = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PUSH) idx_q <= idx_q + 2'd1;
			else                    idx_q <= '0;
		end
	end

endmodule

/* rtl/lcdq_datapath.sv */
// Action memory, pointers, timing and result register of the LCD command queue.
// Depends on lcdq_pkg; controlled by lcdq_ctrl through dp_cmd_t / dp_status_t.
module lcdq_datapath #(
	parameter int QUEUE_DEPTH = lcdq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = lcdq_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lcdq_pkg::dp_cmd_t                cmd,
	output lcdq_pkg::dp_status_t             status,
	input  logic [lcdq_pkg::REQ_W-1:0]       in_req_type,
	input  logic [lcdq_pkg::NOW_W-1:0]       in_now_time,
	input  logic [lcdq_pkg::BYTE_W-1:0]      in_byte_value,
	input  logic [lcdq_pkg::BYTE_W-1:0]      in_wait_count,
	input  logic [lcdq_pkg::ROW_W-1:0]       in_row,
	input  logic [lcdq_pkg::COL_W-1:0]       in_column,
	input  logic                             cfg_we,
	input  logic [lcdq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdq_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             out_bus_write,
	output logic                             out_reg_select,
	output logic [lcdq_pkg::BYTE_W-1:0]      out_bus_byte,
	output logic                             out_dropped,
	output logic [lcdq_pkg::QCOUNT_W-1:0]    out_queue_count
);
	import lcdq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	action_t mem [QUEUE_DEPTH];

	logic [PTR_W-1:0]     rptr_q, wptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] last_time_q;
	logic [BYTE_W-1:0]    clr_wait_q, chr_wait_q;
	logic                 out_valid_q;

	// request held for the duration of the transaction
	logic [REQ_W-1:0]     req_q;
	logic [TIME_BITS-1:0] now_q;
	logic [BYTE_W-1:0]    byte_q, wcount_q, addr_q;

	action_t              head_q;
	logic                 bw_q, rs_q, drop_q;
	logic [BYTE_W-1:0]    bb_q;

	logic                 out_bw_q, out_rs_q, out_drop_q;
	logic [BYTE_W-1:0]    out_bb_q;
	logic [CNT_W-1:0]     out_cnt_q;

	logic [NEED_W-1:0]    need;
	logic [CNT_W-1:0]     free_cnt;
	logic [TIME_BITS-1:0] elapsed;
	logic                 head_is_bus;
	logic                 pop;
	action_t              new_entry;

	assign need        = need_of(req_q);
	assign free_cnt    = CNT_FULL - count_q;
	assign elapsed     = now_q - last_time_q;
	assign head_is_bus = (head_q.kind == KIND_INSTR) || (head_q.kind == KIND_DATA);
	// anything that is not a bus write holds until the elapsed time exceeds its count
	assign pop         = head_is_bus || (TIME_BITS'(head_q.value) < elapsed);
	assign new_entry   = push_entry(req_q, cmd.push_idx, byte_q, wcount_q, addr_q,
		clr_wait_q, chr_wait_q);

	always_comb begin
		status          = '0;
		status.is_proc  = (req_q == REQ_PROCESS);
		status.nonempty = (count_q != '0);
		status.need     = need;
		status.fits     = ({1'b0, free_cnt} >= (CNT_W + 1)'(need));
		status.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) mem[wptr_q] <= new_entry;
		if (cmd.decode) head_q <= mem[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= in_req_type;
			now_q    <= TIME_BITS'(in_now_time);
			byte_q   <= in_byte_value;
			wcount_q <= in_wait_count;
			addr_q   <= SET_DDRAM_BASE + ROW_BASE[in_row] + BYTE_W'(in_column);
			bw_q     <= 1'b0;
			rs_q     <= 1'b0;
			bb_q     <= '0;
		end
		if (cmd.decode) drop_q <= (need != '0) && !status.fits;
		if (cmd.exec && head_is_bus) begin
			bw_q <= 1'b1;
			rs_q <= (head_q.kind == KIND_DATA);
			bb_q <= head_q.value;
		end
		if (cmd.finish) begin
			out_bw_q   <= bw_q;
			out_rs_q   <= rs_q;
			out_bb_q   <= bb_q;
			out_drop_q <= drop_q;
			out_cnt_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q      <= '0;
			wptr_q      <= '0;
			count_q     <= '0;
			last_time_q <= '0;
			clr_wait_q  <= CLEAR_WAIT_RST;
			chr_wait_q  <= CHAR_WAIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CLEAR_WAIT: clr_wait_q <= cfg_wdata;
					CFG_CHAR_WAIT:  chr_wait_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.exec && pop) begin
				rptr_q      <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
				count_q     <= count_q - 1'b1;
				last_time_q <= now_q;
			end
			if (cmd.push) begin
				wptr_q  <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.finish)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_bus_write   = out_bw_q;
	assign out_reg_select  = out_rs_q;
	assign out_bus_byte    = out_bb_q;
	assign out_dropped     = out_drop_q;
	assign out_queue_count = QCOUNT_W'(out_cnt_q);

endmodule

/* rtl/char_lcd_timed_command_queue_top.sv */
// Top level of the LCD timed command queue: controller, datapath and checks.
// Depends on lcdq_pkg, lcdq_if, lcdq_ctrl and lcdq_datapath.
//
// Requests queue display actions (instruction, data, wait) for a 20x4 character
// LCD, one request per transaction, and every request returns exactly one result.
// A process request reads the head action and, if it is a bus write or an elapsed
// wait, pops it, passing from idle through decode and exec to done. A push request
// writes its actions one per cycle through the single write port of the action
// memory in the push state: one for a single push, two for a text character and
// four for clear or character at position. A dropped or unknown request, or a
// process request on an empty queue, goes from decode straight to done. The
// result is valid in the cycle in which the next request can be taken. The memory
// read is registered, which sets the extra decode cycle. A new request is taken
// once the previous one is finished, even while its result still waits in the
// output register; the result register stalls the sequencer only when a second
// result is ready before the first was taken.
module char_lcd_timed_command_queue_top #(
	parameter int QUEUE_DEPTH = lcdq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = lcdq_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lcdq_req_if.sink                       req,
	lcdq_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [lcdq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcdq_pkg::CFG_W-1:0]     cfg_wdata
);
	import lcdq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	lcdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lcdq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_req_type     (req.req_type),
		.in_now_time     (req.now_time),
		.in_byte_value   (req.byte_value),
		.in_wait_count   (req.wait_count),
		.in_row          (req.row),
		.in_column       (req.column),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.out_bus_write   (res.bus_write),
		.out_reg_select  (res.reg_select),
		.out_bus_byte    (res.bus_byte),
		.out_dropped     (res.dropped),
		.out_queue_count (res.queue_count)
	);

	// a request either executes a write or is dropped, never both
	a_write_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.bus_write && res.dropped))
		else $error("bus write and drop in one result");

	// no bus write leaves select and byte at zero
	a_idle_bus_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.bus_write) |-> (!res.reg_select && res.bus_byte == '0))
		else $error("bus fields set without a bus write");

	// one request at a time: ready drops right after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in progress");

	// a result rises only after the request channel has dropped ready
	a_result_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> !$past(req.ready))
		else $error("result without a preceding request");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for char_lcd_timed_command_queue_top: directed and random LCD requests,
// with a local model of the action queue that predicts the status of every request.
// Depends on lcdq_pkg, lcdq_if and the top-level RTL.
module tb;
	import lcdq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_RESERVED = 3'd7;
	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int STALL_LIMIT = 5000;

	typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} load_mode_t;

	typedef struct {
		logic [REQ_W-1:0]  kind;
		logic [NOW_W-1:0]  now;
		logic [BYTE_W-1:0] byte_v;
		logic [BYTE_W-1:0] wcount;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} lcd_req_t;

	typedef struct {
		logic                bus_write;
		logic                reg_select;
		logic [BYTE_W-1:0]   bus_byte;
		logic                dropped;
		logic [QCOUNT_W-1:0] queue_count;
	} lcd_status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	lcdq_req_if req_ch();
	lcdq_res_if res_ch();

	char_lcd_timed_command_queue_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// model of the action queue
	action_t lcd_actions [DEPTH];
	logic [PTR_W-1:0] head_idx;
	logic [PTR_W-1:0] tail_idx;
	int unsigned held;
	logic [NOW_W-1:0] last_exec;
	logic [BYTE_W-1:0] clear_wait;
	logic [BYTE_W-1:0] char_wait;

	lcd_req_t request_backlog[$];
	lcd_status_t status_due[$];
	logic [NOW_W-1:0] lcd_clock;
	bit no_idle;
	int fail_count;

	function automatic void queue_action(logic [1:0] kind, logic [BYTE_W-1:0] value);
		lcd_actions[tail_idx] = '{kind: kind, value: value};
		tail_idx++;
		held++;
	endfunction

	function automatic lcd_status_t exec_lcd_request(lcd_req_t r);
		lcd_status_t s;
		int unsigned room;
		logic fire;
		logic [NOW_W-1:0] elapsed;
		logic [BYTE_W-1:0] addr;
		s = '{default: '0};
		if (r.kind == REQ_PROCESS) begin
			if (held != 0) begin
				fire = 1'b1;
				if (lcd_actions[head_idx].kind == KIND_WAIT) begin
					elapsed = r.now - last_exec;
					fire = NOW_W'(lcd_actions[head_idx].value) < elapsed;
				end else begin
					s.bus_write = 1'b1;
					s.reg_select = lcd_actions[head_idx].kind == KIND_DATA;
					s.bus_byte = lcd_actions[head_idx].value;
				end
				if (fire) begin
					head_idx++;
					held--;
					last_exec = r.now;
				end
			end
		end else if (r.kind != REQ_RESERVED) begin
			case (r.kind)
				REQ_CLEAR, REQ_CHAR_AT: room = 4;
				REQ_TEXT:               room = 2;
				default:                room = 1;
			endcase
			if (DEPTH - held < room) begin
				s.dropped = 1'b1;
			end else begin
				case (r.kind)
					REQ_PUSH_INSTR: queue_action(KIND_INSTR, r.byte_v);
					REQ_PUSH_DATA:  queue_action(KIND_DATA, r.byte_v);
					REQ_PUSH_WAIT:  queue_action(KIND_WAIT, r.wcount);
					REQ_CLEAR: begin
						queue_action(KIND_INSTR, INSTR_CLEAR);
						queue_action(KIND_WAIT, clear_wait);
						queue_action(KIND_INSTR, INSTR_HOME);
						queue_action(KIND_WAIT, clear_wait);
					end
					REQ_TEXT: begin
						queue_action(KIND_DATA, r.byte_v);
						queue_action(KIND_WAIT, char_wait);
					end
					default: begin
						// address is computed modulo 256; columns past the row end are not clamped
						addr = SET_DDRAM_BASE + ROW_BASE[r.row] + BYTE_W'(r.col);
						queue_action(KIND_INSTR, addr);
						queue_action(KIND_WAIT, char_wait);
						queue_action(KIND_DATA, r.byte_v);
						queue_action(KIND_WAIT, char_wait);
					end
				endcase
			end
		end
		s.queue_count = QCOUNT_W'(held);
		return s;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// mostly small steps so waits expire over several process requests
	function automatic logic [NOW_W-1:0] advance_clock();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			lcd_clock = lcd_clock + $urandom_range(0, 48);
		else if (r < 95)
			lcd_clock = lcd_clock + $urandom_range(100, 400);
		else
			lcd_clock = $urandom();
		return lcd_clock;
	endfunction

	function automatic lcd_req_t random_request(load_mode_t mode);
		lcd_req_t r;
		int unsigned push_pct;
		r.now = $urandom();
		r.byte_v = BYTE_W'($urandom_range(0, 255));
		r.wcount = BYTE_W'($urandom_range(0, 255));
		r.row = ROW_W'($urandom_range(0, 3));
		r.col = ($urandom_range(0, 4) == 0) ? COL_W'($urandom_range(0, 31))
			: COL_W'($urandom_range(0, 19));
		push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 25 : 50;
		if ($urandom_range(0, 99) < 3) begin
			r.kind = REQ_RESERVED;
		end else if ($urandom_range(0, 99) < push_pct) begin
			r.kind = REQ_W'($urandom_range(REQ_PUSH_INSTR, REQ_CHAR_AT));
		end else begin
			r.kind = REQ_PROCESS;
			r.now = advance_clock();
		end
		if (r.kind == REQ_PUSH_WAIT && $urandom_range(0, 3) != 0)
			r.wcount = BYTE_W'($urandom_range(0, 40));
		return r;
	endfunction

	function automatic lcd_req_t make_req(logic [REQ_W-1:0] kind, logic [NOW_W-1:0] now,
		logic [BYTE_W-1:0] byte_v, logic [BYTE_W-1:0] wcount,
		logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		lcd_req_t r;
		r = '{kind: kind, now: now, byte_v: byte_v, wcount: wcount, row: row, col: col};
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			fail_count++;
		end
	endfunction

	// request driver
	lcd_req_t on_bus;
	int send_gap;
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= '0;
			req_ch.now_time <= '0;
			req_ch.byte_value <= '0;
			req_ch.wait_count <= '0;
			req_ch.row <= '0;
			req_ch.column <= '0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				status_due.push_back(exec_lcd_request(on_bus));
				send_gap = pick_gap();
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					on_bus = request_backlog.pop_front();
					req_ch.req_type <= on_bus.kind;
					req_ch.now_time <= on_bus.now;
					req_ch.byte_value <= on_bus.byte_v;
					req_ch.wait_count <= on_bus.wcount;
					req_ch.row <= on_bus.row;
					req_ch.column <= on_bus.col;
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int recv_stall;
	lcd_status_t want;
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (status_due.size() == 0) begin
					$error("result transaction with no request outstanding");
					fail_count++;
				end else begin
					want = status_due.pop_front();
					check_field("bus_write", 32'(want.bus_write), 32'(res_ch.bus_write));
					check_field("reg_select", 32'(want.reg_select), 32'(res_ch.reg_select));
					check_field("bus_byte", 32'(want.bus_byte), 32'(res_ch.bus_byte));
					check_field("dropped", 32'(want.dropped), 32'(res_ch.dropped));
					check_field("queue_count", 32'(want.queue_count),
						32'(res_ch.queue_count));
				end
				recv_stall = pick_gap();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles without any transaction or register write
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == CFG_CLEAR_WAIT)
			clear_wait = value;
		else
			char_wait = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sampled at the falling edge so the driver's updates have settled
	task automatic drain_all();
		while (request_backlog.size() != 0 || req_ch.valid || status_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(logic [CFG_W-1:0] clr, logic [CFG_W-1:0] chr, load_mode_t mode,
		int n, bit steady);
		write_reg(CFG_CLEAR_WAIT, clr);
		write_reg(CFG_CHAR_WAIT, chr);
		no_idle = steady;
		for (int i = 0; i < n; i++)
			request_backlog.push_back(random_request(mode));
		drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		fail_count = 0;
		no_idle = 1'b0;
		head_idx = '0;
		tail_idx = '0;
		held = 0;
		last_exec = '0;
		clear_wait = CLEAR_WAIT_RST;
		char_wait = CHAR_WAIT_RST;
		lcd_clock = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset register values, empty queue, wait boundaries, time wrap
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd0, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_RESERVED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 2'd3, 5'd31));
		request_backlog.push_back(make_req(REQ_PUSH_INSTR, 32'd0, 8'hFF, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PUSH_DATA, 32'd0, 8'h00, 8'hFF, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PUSH_WAIT, 32'd0, 8'h00, 8'hFF, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PUSH_WAIT, 32'd0, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd10, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd20, 8'h00, 8'h00, 2'd0, 5'd0));
		// elapsed equal to the count holds, one more releases
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd275, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd276, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd276, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'd277, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_CLEAR, 32'd0, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_TEXT, 32'd0, 8'h41, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_CHAR_AT, 32'd0, 8'hFF, 8'h00, 2'd3, 5'd19));
		request_backlog.push_back(make_req(REQ_CHAR_AT, 32'd0, 8'h80, 8'h00, 2'd1, 5'd31));
		request_backlog.push_back(make_req(REQ_CHAR_AT, 32'd0, 8'h20, 8'h00, 2'd2, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'hFFFF_FFF0, 8'h00, 8'h00, 2'd0, 5'd0));
		// elapsed measured across the 32-bit wrap
		request_backlog.push_back(make_req(REQ_PROCESS, 32'h0000_0050, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'h0000_0070, 8'h00, 8'h00, 2'd0, 5'd0));
		request_backlog.push_back(make_req(REQ_PROCESS, 32'h0000_0070, 8'h00, 8'h00, 2'd0, 5'd0));
		lcd_clock = 32'h0000_0070;
		drain_all();

		run_phase(CLEAR_WAIT_RST, CHAR_WAIT_RST, MODE_MIX, 150, 1'b0);
		run_phase(8'd0, 8'd0, MODE_FILL, 200, 1'b0);
		run_phase(8'd0, 8'd0, MODE_DRAIN, 150, 1'b0);
		run_phase(8'd255, 8'd255, MODE_MIX, 200, 1'b1);
		run_phase(8'd255, 8'd255, MODE_DRAIN, 100, 1'b0);
		run_phase(8'd1, 8'd254, MODE_FILL, 150, 1'b0);
		run_phase(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)), MODE_MIX, 200,
			1'b0);
		run_phase(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)), MODE_DRAIN,
			150, 1'b1);
		run_phase(8'd254, 8'd1, MODE_MIX, 230, 1'b0);

		repeat (20) @(posedge clk);
		if (status_due.size() != 0) begin
			$error("%0d results never arrived", status_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* char_lcd_timed_command_queue_top.f */
rtl/lcdq_pkg.sv
rtl/lcdq_if.sv
rtl/lcdq_ctrl.sv
rtl/lcdq_datapath.sv
rtl/char_lcd_timed_command_queue_top.sv
test/tb.sv
